### design/rlfe_pkg.sv
// shared types, codes and helpers of the rgbw fade engine
`default_nettype none
package rlfe_pkg;

   localparam logic [1:0] FUNC_FADE = 2'd0;
   localparam logic [1:0] FUNC_LAST = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   localparam logic [2:0] CSR_COMMON_CATHODE = 3'd0;
   localparam logic [2:0] CSR_MAX_LEVEL      = 3'd1;
   localparam logic [2:0] CSR_DEFAULT_FIRST  = 3'd2;

   typedef struct packed {
      logic start;     // latch start colour and target, run the increment divide
      logic sel_last;  // target comes from the last colour
      logic save_last; // last colour takes the requested colour
      logic snap;      // current level jumps to the requested level
      logic mul;       // form step times increment
      logic apply;     // write the interpolated level
      logic cfg_wr;    // default colour written for this channel
   } lane_ctrl_type;

   typedef struct packed {
      logic tgt_differ;
      logic req_nonzero;
      logic raw_nonzero;
      logic busy;
   } lane_stat_type;

   // v * max / 255 for 8-bit values, divide by 255 as add and shift
   function automatic logic [7:0] scale_level(input logic [7:0] v, input logic [7:0] max_lvl);
      logic [15:0] p;
      logic [16:0] s;
      begin
         p = v * max_lvl;
         s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
         scale_level = s[15:8];
      end
   endfunction

endpackage
`default_nettype wire

### design/rlfe_divider.sv
// restoring divider, one quotient bit a cycle
`default_nettype none
module rlfe_divider #(
   parameter int W = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              busy,
   output logic [W-1:0]      quotient
);
   localparam int CW = $clog2(W + 1);

   logic [W:0]    rem_ff, rem_in, shifted;
   logic [W-1:0]  quo_ff, quo_in, div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, ge;

   always_comb begin
      shifted = {rem_ff[W-1:0], quo_ff[W-1]};
      ge      = shifted >= {1'b0, div_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? (shifted - {1'b0, div_ff}) : shifted;
         quo_in  = {quo_ff[W-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         busy_in = cnt_ff != CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

### design/rlfe_lane.sv
// one colour channel: levels, increment divide and interpolation
`default_nettype none
module rlfe_lane (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rlfe_pkg::lane_ctrl_type ctrl,
   input  wire logic [7:0]            raw_level,
   input  wire logic [7:0]            max_level,
   input  wire logic [7:0]            cfg_value,
   input  wire logic [15:0]           steps,
   input  wire logic [15:0]           step,
   output rlfe_pkg::lane_stat_type    stat,
   output logic [7:0]                 current_level
);
   logic [7:0]  req_ff, req_in, cur_ff, cur_in, start_ff, start_in, last_ff, last_in;
   logic        neg_ff, neg_in;
   logic [7:0]  tgt, mag;
   logic [8:0]  diff;
   logic [15:0] quo;
   logic        busy;
   logic signed [17:0] inc;
   logic signed [34:0] prod_ff, prod_in;
   logic signed [35:0] val;

   rlfe_divider #(.W(16)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.start),
      .dividend ({mag, 8'd0}),
      .divisor  (steps),
      .busy     (busy),
      .quotient (quo)
   );

   always_comb begin
      tgt  = ctrl.sel_last ? last_ff : rlfe_pkg::scale_level(raw_level, max_level);
      diff = {1'b0, tgt} - {1'b0, cur_ff};
      mag  = diff[8] ? 8'(-diff) : diff[7:0];
      inc  = neg_ff ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
      prod_in = ctrl.mul ? $signed({1'b0, step}) * inc : prod_ff;
      val  = $signed({20'd0, start_ff, 8'd0}) + 36'(prod_ff);

      req_in   = req_ff;
      cur_in   = cur_ff;
      start_in = start_ff;
      last_in  = last_ff;
      neg_in   = neg_ff;
      if (ctrl.cfg_wr) last_in = rlfe_pkg::scale_level(cfg_value, max_level);
      if (ctrl.save_last) last_in = req_ff;
      if (ctrl.start) begin
         req_in   = tgt;
         start_in = cur_ff;
         neg_in   = diff[8];
      end
      if (ctrl.snap) cur_in = req_ff;
      if (ctrl.apply) begin
         if (val < 0) cur_in = 8'd0;
         else if (val[35:8] > 28'd255) cur_in = 8'd255;
         else cur_in = val[15:8];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         req_ff   <= '0;
         cur_ff   <= '0;
         start_ff <= '0;
         last_ff  <= '0;
         neg_ff   <= 1'b0;
      end else begin
         req_ff   <= req_in;
         cur_ff   <= cur_in;
         start_ff <= start_in;
         last_ff  <= last_in;
         neg_ff   <= neg_in;
      end
   end

   assign stat.tgt_differ  = tgt != req_ff;
   assign stat.req_nonzero = req_ff != 8'd0;
   assign stat.raw_nonzero = raw_level != 8'd0;
   assign stat.busy        = busy;
   assign current_level    = cur_ff;
endmodule
`default_nettype wire

### design/rgbw_linear_fade_engine.sv
// top level of the four-channel rgbw linear fade engine
// use: the req channel carries fade requests (func fade, fade to last) and
// one-millisecond ticks; every item gives exactly one rsp item with the drive
// levels after polarity, whether they changed, and the fading / active flags
// - one item at a time; req_ready is high only while the engine is idle
// - a request with unchanged targets goes from eval straight to done, as does
//   a tick with no running fade; a tick past a fade's start delay runs the
//   shared bit-serial divider that turns elapsed time into a step number,
//   and a new step then passes mul and apply; a fade start runs the step delay
//   divide on the shared divider while each lane divides its own 8.8 increment
// - the rsp register holds a result until taken; the next item is worked on
//   meanwhile and waits only if its own result finds the register still full
// reset: fades stop, levels and last colour are cleared, common cathode on,
// max level 255, time zero; csr writes take effect at once and should be
// made only while the engine is idle
`default_nettype none
module rgbw_linear_fade_engine #(
   parameter int CHANNELS  = 4,
   parameter int TIME_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   input  wire logic [7:0]  req_white,
   input  wire logic [15:0] req_step_total,
   input  wire logic [31:0] req_duration_ms,
   input  wire logic [31:0] req_start_delay_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_drive_red,
   output logic [7:0]       rsp_drive_green,
   output logic [7:0]       rsp_drive_blue,
   output logic [7:0]       rsp_drive_white,
   output logic             rsp_drive_updated,
   output logic             rsp_is_fading,
   output logic             rsp_is_active,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_data
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EVAL  = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_APPLY = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;
   localparam logic [TIME_BITS-1:0] TIME_ONE = TIME_BITS'(1);

   logic [2:0] state_ff, state_in;

   // captured item
   logic [1:0]           func_ff;
   logic [3:0][7:0]      raw_ff;
   logic [15:0]          steps_ff;
   logic [TIME_BITS-1:0] dur_ff, delay_ff;

   // fade state
   logic [TIME_BITS-1:0] now_ff, now_in, fstart_ff, fstart_in, sdelay_ff, sdelay_in;
   logic [15:0]          count_ff, count_in, prev_ff, prev_in, stepv_ff, stepv_in;
   logic                 active_ff, active_in, updated_ff, updated_in, tickmode_ff, tickmode_in;

   // config
   logic       cc_ff;
   logic [7:0] max_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0][7:0] drv_ff, drv_in;
   logic       upd_o_ff, fad_o_ff, act_o_ff;

   // lanes
   rlfe_pkg::lane_ctrl_type lctrl;
   rlfe_pkg::lane_stat_type [CHANNELS-1:0] lstat;
   logic [CHANNELS-1:0][7:0] lcur;
   logic [CHANNELS-1:0] lcfg;
   logic any_differ, any_req, any_raw, any_busy, any_active;

   // shared divider
   logic                 dv_start, dv_busy;
   logic [TIME_BITS-1:0] dv_dividend, dv_divisor, dv_quo;
   logic [TIME_BITS-1:0] now_next, elapsed;

   rlfe_divider #(.W(TIME_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_dividend),
      .divisor  (dv_divisor),
      .busy     (dv_busy),
      .quotient (dv_quo)
   );

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      rlfe_pkg::lane_ctrl_type ctl;
      always_comb begin
         ctl        = lctrl;
         ctl.cfg_wr = lcfg[c];
      end
      rlfe_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctl),
         .raw_level     (raw_ff[c]),
         .max_level     (max_ff),
         .cfg_value     (csr_data),
         .steps         (steps_ff),
         .step          (stepv_ff),
         .stat          (lstat[c]),
         .current_level (lcur[c])
      );
      assign lcfg[c] = csr_write_enable
                       && csr_index == rlfe_pkg::CSR_DEFAULT_FIRST + 3'(c);
   end

   // merge of lane findings
   always_comb begin
      any_differ = 1'b0;
      any_req    = 1'b0;
      any_raw    = 1'b0;
      any_busy   = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         any_differ = any_differ | lstat[c].tgt_differ;
         any_req    = any_req | lstat[c].req_nonzero;
         any_raw    = any_raw | lstat[c].raw_nonzero;
         any_busy   = any_busy | lstat[c].busy;
      end
      any_active = any_req | active_ff;
   end

   assign now_next = now_ff + TIME_ONE;
   assign elapsed  = now_next - fstart_ff;

   always_comb begin
      state_in    = state_ff;
      now_in      = now_ff;
      fstart_in   = fstart_ff;
      sdelay_in   = sdelay_ff;
      count_in    = count_ff;
      prev_in     = prev_ff;
      stepv_in    = stepv_ff;
      active_in   = active_ff;
      updated_in  = updated_ff;
      tickmode_in = tickmode_ff;
      lctrl       = '0;
      lctrl.sel_last = func_ff == rlfe_pkg::FUNC_LAST;
      dv_start    = 1'b0;
      dv_dividend = dur_ff;
      dv_divisor  = TIME_BITS'(steps_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      drv_in      = drv_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EVAL;
         end
         S_EVAL: begin
            updated_in = 1'b0;
            state_in   = S_DONE;
            if (func_ff == rlfe_pkg::FUNC_FADE || func_ff == rlfe_pkg::FUNC_LAST) begin
               lctrl.save_last = func_ff == rlfe_pkg::FUNC_FADE && !any_raw;
               if (any_differ && (func_ff == rlfe_pkg::FUNC_FADE || !any_active)) begin
                  lctrl.start = 1'b1;
                  dv_start    = 1'b1;
                  count_in    = steps_ff;
                  prev_in     = '0;
                  active_in   = 1'b1;
                  fstart_in   = now_ff + delay_ff;
                  tickmode_in = 1'b0;
                  state_in    = S_DIV;
               end
            end else if (func_ff == rlfe_pkg::FUNC_TICK) begin
               now_in = now_next;
               if (active_ff && elapsed != '0 && !elapsed[TIME_BITS-1]) begin
                  dv_start    = 1'b1;
                  dv_dividend = elapsed;
                  dv_divisor  = sdelay_ff;
                  tickmode_in = 1'b1;
                  state_in    = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (!dv_busy && !any_busy) begin
               state_in = S_DONE;
               if (!tickmode_ff) begin
                  sdelay_in = (dv_quo == '0) ? TIME_ONE : dv_quo;
               end else if (dv_quo >= TIME_BITS'(count_ff)) begin
                  active_in   = 1'b0;
                  lctrl.snap  = 1'b1;
                  updated_in  = 1'b1;
               end else if (dv_quo[15:0] != prev_ff) begin
                  stepv_in   = dv_quo[15:0];
                  prev_in    = dv_quo[15:0];
                  updated_in = 1'b1;
                  state_in   = S_MUL;
               end
            end
         end
         S_MUL: begin
            lctrl.mul = 1'b1;
            state_in  = S_APPLY;
         end
         S_APPLY: begin
            lctrl.apply = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               for (int c = 0; c < 4; c++) begin
                  drv_in[c] = '0;
                  if (c < CHANNELS) drv_in[c] = cc_ff ? lcur[c] : max_ff - lcur[c];
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         func_ff  <= req_func;
         raw_ff   <= {req_white, req_blue, req_green, req_red};
         steps_ff <= (req_step_total == 16'd0) ? 16'd1 : req_step_total;
         dur_ff   <= req_duration_ms[TIME_BITS-1:0];
         delay_ff <= req_start_delay_ms[TIME_BITS-1:0];
      end
      stepv_ff <= stepv_in;
      drv_ff   <= drv_in;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         upd_o_ff <= updated_ff;
         fad_o_ff <= active_ff;
         act_o_ff <= any_active;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         now_ff       <= '0;
         fstart_ff    <= '0;
         sdelay_ff    <= TIME_ONE;
         count_ff     <= '0;
         prev_ff      <= '0;
         active_ff    <= 1'b0;
         updated_ff   <= 1'b0;
         tickmode_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cc_ff        <= 1'b1;
         max_ff       <= 8'd255;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         fstart_ff    <= fstart_in;
         sdelay_ff    <= sdelay_in;
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         active_ff    <= active_in;
         updated_ff   <= updated_in;
         tickmode_ff  <= tickmode_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable && csr_index == rlfe_pkg::CSR_COMMON_CATHODE) cc_ff <= csr_data[0];
         if (csr_write_enable && csr_index == rlfe_pkg::CSR_MAX_LEVEL) max_ff <= csr_data;
      end
   end

   assign req_ready         = state_ff == S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_red     = drv_ff[0];
   assign rsp_drive_green   = drv_ff[1];
   assign rsp_drive_blue    = drv_ff[2];
   assign rsp_drive_white   = drv_ff[3];
   assign rsp_drive_updated = upd_o_ff;
   assign rsp_is_fading     = fad_o_ff;
   assign rsp_is_active     = act_o_ff;

`ifndef SYNTH
   // an accepted item always goes to evaluation next
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_EVAL)
      else $error("accepted item not evaluated");
   // a running fade never divides by zero
   a_delay_nonzero: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> sdelay_ff != '0 || state_ff == S_DIV)
      else $error("fade running with zero step delay");
   // a running fade has at least one step
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> count_ff != '0)
      else $error("fade running with zero steps");
`endif
endmodule
`default_nettype wire
